@@ sv/rrcp_pkg.sv @@
// rrcp_pkg: shared widths, register indexes, controller states and the
// command/status structs of the record range copy planner
// no dependencies
`default_nettype none

package rrcp_pkg;

   // default table depth and the cap on descriptors per request
   localparam int MAX_RECORDS_DEF = 32;
   localparam int MAX_RESULTS     = 32;

   // payload widths
   localparam int FW     = 48;
   localparam int IDX_W  = 6;
   localparam int RC_W   = 6;
   localparam int CPB_W  = 16;
   localparam int ISZ_W  = 4;
   localparam int CSR_IW = 2;
   localparam int CSR_DW = 16;

   // configuration register indexes
   localparam logic [CSR_IW-1:0] CSR_RECORD_COUNT = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_COL_PREFIX   = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_ITEM_SIZE    = 2'd2;

   // request modes
   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_RANGE = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_WALK_RD,
      ST_WALK_EV1,
      ST_WALK_EV2,
      ST_WALK_MUL,
      ST_WALK_SUM,
      ST_PUSH,
      ST_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load_wr;
      logic start_req;
      logic srch_rd;
      logic srch_upd;
      logic walk_init;
      logic ev1;
      logic ev2;
      logic mul;
      logic sum;
      logic next_rec;
      logic push;
      logic finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic req_empty;
      logic cnt_zero;
      logic walk_done;
      logic brk;
      logic seg_ok;
      logic push_ok;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

@@ sv/rrcp_req_if.sv @@
// rrcp_req_if: request channel (table loads and row range requests)
// depends on rrcp_pkg
`default_nettype none

interface rrcp_req_if import rrcp_pkg::*;;
   logic             valid;
   logic             ready;
   logic             mode;
   logic [IDX_W-1:0] entry_index;
   logic [FW-1:0]    entry_first_row;
   logic [FW-1:0]    entry_first_byte;
   logic [FW-1:0]    entry_row_count;
   logic [FW-1:0]    range_start;
   logic [FW-1:0]    range_stop;

   modport source (
      output valid, mode, entry_index, entry_first_row, entry_first_byte,
             entry_row_count, range_start, range_stop,
      input  ready
   );

   modport sink (
      input  valid, mode, entry_index, entry_first_row, entry_first_byte,
             entry_row_count, range_start, range_stop,
      output ready
   );
endinterface

`default_nettype wire

@@ sv/rrcp_rsp_if.sv @@
// rrcp_rsp_if: copy descriptor channel
// depends on rrcp_pkg
`default_nettype none

interface rrcp_rsp_if import rrcp_pkg::*;;
   logic          valid;
   logic          ready;
   logic [FW-1:0] source_offset;
   logic [FW-1:0] dest_offset;
   logic [FW-1:0] byte_count;
   logic          empty_res;
   logic          overflow;
   logic          last;

   modport source (
      output valid, source_offset, dest_offset, byte_count, empty_res,
             overflow, last,
      input  ready
   );

   modport sink (
      input  valid, source_offset, dest_offset, byte_count, empty_res,
             overflow, last,
      output ready
   );
endinterface

`default_nettype wire

@@ sv/rrcp_ram.sv @@
// rrcp_ram: generic simple dual port ram, one write and one registered read
// no dependencies
`default_nettype none

module rrcp_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 32
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

@@ sv/rrcp_ctrl.sv @@
// rrcp_ctrl: sequencer for table loads, the upper-bound search and the
// record walk; depends on rrcp_pkg
`default_nettype none

module rrcp_ctrl import rrcp_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_mode,
   output logic         req_ready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && (req_mode == MODE_RANGE)) begin
               state_in = sts.req_empty ? ST_FINISH : ST_SRCH_RD;
            end
         end
         ST_SRCH_RD: begin
            state_in = sts.cnt_zero ? ST_WALK_RD : ST_SRCH_CMP;
         end
         ST_SRCH_CMP: state_in = ST_SRCH_RD;
         ST_WALK_RD: begin
            state_in = sts.walk_done ? ST_FINISH : ST_WALK_EV1;
         end
         ST_WALK_EV1: begin
            state_in = sts.brk ? ST_FINISH : ST_WALK_EV2;
         end
         ST_WALK_EV2: begin
            state_in = sts.seg_ok ? ST_WALK_MUL : ST_WALK_RD;
         end
         ST_WALK_MUL: state_in = ST_WALK_SUM;
         ST_WALK_SUM: state_in = ST_PUSH;
         ST_PUSH: begin
            if (sts.push_ok) begin
               state_in = ST_WALK_RD;
            end
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_wr   = req_valid && (req_mode == MODE_LOAD);
            cmd.start_req = req_valid && (req_mode == MODE_RANGE);
         end
         ST_SRCH_RD: begin
            cmd.srch_rd   = !sts.cnt_zero;
            cmd.walk_init = sts.cnt_zero;
         end
         ST_SRCH_CMP: cmd.srch_upd = 1'b1;
         ST_WALK_RD:  ;
         ST_WALK_EV1: cmd.ev1 = 1'b1;
         ST_WALK_EV2: begin
            cmd.ev2      = 1'b1;
            cmd.next_rec = !sts.seg_ok;
         end
         ST_WALK_MUL: cmd.mul = 1'b1;
         ST_WALK_SUM: cmd.sum = 1'b1;
         ST_PUSH:     cmd.push = sts.push_ok;
         ST_FINISH:   cmd.finish = sts.out_free;
         default:     ;
      endcase
   end

endmodule

`default_nettype wire

@@ sv/rrcp_datapath.sv @@
// rrcp_datapath: config registers, record tables, search and walk registers,
// descriptor arithmetic, pending descriptor and output register
// depends on rrcp_pkg and rrcp_ram
`default_nettype none

module rrcp_datapath import rrcp_pkg::*; #(
   parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cmd_type           cmd,
   output sts_type                sts,
   input  wire logic              csr_we,
   input  wire logic [CSR_IW-1:0] csr_index,
   input  wire logic [CSR_DW-1:0] csr_wdata,
   input  wire logic [IDX_W-1:0]  req_entry_index,
   input  wire logic [FW-1:0]     req_entry_first_row,
   input  wire logic [FW-1:0]     req_entry_first_byte,
   input  wire logic [FW-1:0]     req_entry_row_count,
   input  wire logic [FW-1:0]     req_range_start,
   input  wire logic [FW-1:0]     req_range_stop,
   input  wire logic              rsp_ready,
   output logic                   rsp_valid,
   output logic [FW-1:0]          rsp_source_offset,
   output logic [FW-1:0]          rsp_dest_offset,
   output logic [FW-1:0]          rsp_byte_count,
   output logic                   rsp_empty_res,
   output logic                   rsp_overflow,
   output logic                   rsp_last
);

   localparam int IW = $clog2(MAX_RECORDS + 1);
   localparam int CW = $clog2(MAX_RECORDS + 2);
   localparam int DW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
   localparam int KW = $clog2(MAX_RESULTS + 1);

   // config registers
   logic [RC_W-1:0]  rec_cnt_ff;
   logic [CPB_W-1:0] col_pre_ff;
   logic [ISZ_W-1:0] item_size_ff;

   // request and walk control
   logic [FW-1:0] start_ff;
   logic [FW-1:0] stop_ff;
   logic [IW-1:0] n_ff;
   logic [IW-1:0] n_calc;
   logic [CW-1:0] first_ff;
   logic [CW-1:0] cnt_ff;
   logic [CW-1:0] step;
   logic [CW-1:0] probe;
   logic [IW-1:0] r_ff;
   logic [KW-1:0] k_ff;

   // tables
   logic            row_we;
   logic            dat_we;
   logic [IW-1:0]   row_rd_addr;
   logic [FW-1:0]   row_rd_data;
   logic [2*FW-1:0] dat_rd_data;

   // walk stages
   logic [FW-1:0]   rs_ff;
   logic [FW-1:0]   rn_ff;
   logic [FW-1:0]   bs_ff;
   logic [FW-1:0]   lo_abs_ff;
   logic [FW:0]     re_ff;
   logic [FW-1:0]   hi_abs;
   logic [FW-1:0]   rows_ff;
   logic [FW-1:0]   lo_ff;
   logic [FW-1:0]   wpos_ff;
   logic [63:0]     pre_prod;
   logic [FW+3:0]   skip_prod;
   logic [FW+3:0]   dst_prod;
   logic [FW+3:0]   bytes_prod;
   logic [FW-1:0]   pre_ff;
   logic [FW-1:0]   skip_ff;
   logic [FW-1:0]   dst_ff;
   logic [FW-1:0]   bytes_ff;
   logic            ovm_ff;
   logic [FW:0]     s1_ff;
   logic [FW:0]     s2;

   // pending descriptor and output register
   logic          pend_valid_ff;
   logic [FW-1:0] pend_src_ff;
   logic [FW-1:0] pend_dst_ff;
   logic [FW-1:0] pend_cnt_ff;
   logic          pend_ovf_ff;
   logic          out_valid_ff;
   logic [FW-1:0] out_src_ff;
   logic [FW-1:0] out_dst_ff;
   logic [FW-1:0] out_cnt_ff;
   logic          out_empty_ff;
   logic          out_ovf_ff;
   logic          out_last_ff;
   logic          out_free;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         rec_cnt_ff   <= '0;
         col_pre_ff   <= '0;
         item_size_ff <= ISZ_W'(1);
      end else if (csr_we) begin
         case (csr_index)
            CSR_RECORD_COUNT: rec_cnt_ff   <= csr_wdata[RC_W-1:0];
            CSR_COL_PREFIX:   col_pre_ff   <= csr_wdata[CPB_W-1:0];
            CSR_ITEM_SIZE:    item_size_ff <= csr_wdata[ISZ_W-1:0];
            default:          ;
         endcase
      end
   end

   // record count clamped to the table depth
   always_comb begin
      if (int'(rec_cnt_ff) > MAX_RECORDS) begin
         n_calc = IW'(MAX_RECORDS);
      end else begin
         n_calc = IW'(rec_cnt_ff);
      end
   end

   // table writes: the end entry only carries a row start
   assign row_we = cmd.load_wr && (int'(req_entry_index) <= MAX_RECORDS);
   assign dat_we = cmd.load_wr && (int'(req_entry_index) < MAX_RECORDS);

   // search probe
   assign step        = cnt_ff >> 1;
   assign probe       = first_ff + step;
   assign row_rd_addr = cmd.srch_rd ? IW'(probe) : r_ff;

   rrcp_ram #(
      .WIDTH (FW),
      .DEPTH (MAX_RECORDS + 1)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (row_we),
      .wr_addr (IW'(req_entry_index)),
      .wr_data (req_entry_first_row),
      .rd_addr (row_rd_addr),
      .rd_data (row_rd_data)
   );

   // byte start in the upper half, row count in the lower half
   rrcp_ram #(
      .WIDTH (2 * FW),
      .DEPTH (MAX_RECORDS)
   ) u_dat_ram (
      .clock   (clock),
      .wr_en   (dat_we),
      .wr_addr (DW'(req_entry_index)),
      .wr_data ({req_entry_first_byte, req_entry_row_count}),
      .rd_addr (DW'(r_ff)),
      .rd_data (dat_rd_data)
   );

   // search and walk counters
   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff     <= '0;
         first_ff <= '0;
         cnt_ff   <= '0;
         r_ff     <= '0;
         k_ff     <= '0;
      end else begin
         if (cmd.start_req) begin
            n_ff     <= n_calc;
            first_ff <= '0;
            cnt_ff   <= CW'(n_calc) + CW'(1);
            k_ff     <= '0;
         end
         if (cmd.srch_upd) begin
            if (!(start_ff < row_rd_data)) begin
               first_ff <= probe + CW'(1);
               cnt_ff   <= cnt_ff - step - CW'(1);
            end else begin
               cnt_ff <= step;
            end
         end
         if (cmd.walk_init) begin
            r_ff <= (first_ff == '0) ? '0 : IW'(first_ff - CW'(1));
         end
         if (cmd.next_rec || cmd.push) begin
            r_ff <= r_ff + IW'(1);
         end
         if (cmd.push) begin
            k_ff <= k_ff + KW'(1);
         end
      end
   end

   // products of the descriptor
   assign pre_prod   = 64'(col_pre_ff) * 64'(rn_ff);
   assign skip_prod  = (FW+4)'(lo_ff) * (FW+4)'(item_size_ff);
   assign dst_prod   = (FW+4)'(wpos_ff) * (FW+4)'(item_size_ff);
   assign bytes_prod = (FW+4)'(rows_ff) * (FW+4)'(item_size_ff);

   // segment end and final source sum
   assign hi_abs = ({1'b0, stop_ff} < re_ff) ? stop_ff : re_ff[FW-1:0];
   assign s2     = {1'b0, s1_ff[FW-1:0]} + {1'b0, skip_ff};

   // walk pipeline registers
   always_ff @(posedge clock) begin
      if (cmd.start_req) begin
         start_ff <= req_range_start;
         stop_ff  <= req_range_stop;
         wpos_ff  <= '0;
      end
      if (cmd.ev1) begin
         rs_ff     <= row_rd_data;
         rn_ff     <= dat_rd_data[FW-1:0];
         bs_ff     <= dat_rd_data[2*FW-1:FW];
         lo_abs_ff <= (start_ff > row_rd_data) ? start_ff : row_rd_data;
         re_ff     <= {1'b0, row_rd_data} + {1'b0, dat_rd_data[FW-1:0]};
      end
      if (cmd.ev2) begin
         rows_ff <= hi_abs - lo_abs_ff;
         lo_ff   <= lo_abs_ff - rs_ff;
      end
      if (cmd.mul) begin
         pre_ff   <= pre_prod[FW-1:0];
         skip_ff  <= skip_prod[FW-1:0];
         dst_ff   <= dst_prod[FW-1:0];
         bytes_ff <= bytes_prod[FW-1:0];
         ovm_ff   <= (|pre_prod[63:FW]) || (|skip_prod[FW+3:FW])
                     || (|dst_prod[FW+3:FW]) || (|bytes_prod[FW+3:FW]);
         wpos_ff  <= wpos_ff + rows_ff;
      end
      if (cmd.sum) begin
         s1_ff <= {1'b0, bs_ff} + {1'b0, pre_ff};
      end
      if (cmd.push) begin
         pend_src_ff <= s2[FW-1:0];
         pend_dst_ff <= dst_ff;
         pend_cnt_ff <= bytes_ff;
         pend_ovf_ff <= ovm_ff || s1_ff[FW] || s2[FW];
      end
   end

   // output register takes the pending descriptor or the empty result
   assign out_free = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (cmd.push) begin
            pend_valid_ff <= 1'b1;
         end else if (cmd.finish) begin
            pend_valid_ff <= 1'b0;
         end
         if (cmd.finish || (cmd.push && pend_valid_ff)) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish && !pend_valid_ff) begin
         out_src_ff   <= '0;
         out_dst_ff   <= '0;
         out_cnt_ff   <= '0;
         out_empty_ff <= 1'b1;
         out_ovf_ff   <= 1'b0;
         out_last_ff  <= 1'b1;
      end else if (cmd.finish || (cmd.push && pend_valid_ff)) begin
         out_src_ff   <= pend_src_ff;
         out_dst_ff   <= pend_dst_ff;
         out_cnt_ff   <= pend_cnt_ff;
         out_empty_ff <= 1'b0;
         out_ovf_ff   <= pend_ovf_ff;
         out_last_ff  <= cmd.finish;
      end
   end

   // status
   always_comb begin
      sts.req_empty = (req_range_stop <= req_range_start) || (n_calc == '0);
      sts.cnt_zero  = (cnt_ff == '0);
      sts.walk_done = (r_ff >= n_ff) || (k_ff == KW'(MAX_RESULTS));
      sts.brk       = (row_rd_data >= stop_ff);
      sts.seg_ok    = (hi_abs > lo_abs_ff);
      sts.push_ok   = !pend_valid_ff || out_free;
      sts.out_free  = out_free;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_source_offset = out_src_ff;
   assign rsp_dest_offset   = out_dst_ff;
   assign rsp_byte_count    = out_cnt_ff;
   assign rsp_empty_res     = out_empty_ff;
   assign rsp_overflow      = out_ovf_ff;
   assign rsp_last          = out_last_ff;

endmodule

`default_nettype wire

@@ sv/record_range_copy_planner.sv @@
// record range copy planner: a load is written when accepted and an empty range closes;
// a range runs a search (row read, compare; up to ceil(log2(n+2)) row reads), then walks
// the records (read, evaluate, multiply, sum, push) and closes; the walk stalls while a
// pending descriptor and the output register are both full
// synchronous active-high reset sets record_count 0, column_prefix_bytes 0, item_size 1
// and empties the output; the record tables are not cleared
`default_nettype none

module record_range_copy_planner import rrcp_pkg::*; #(
   parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   rrcp_req_if.sink               req_if,
   rrcp_rsp_if.source             rsp_if,
   input  wire logic              csr_we,
   input  wire logic [CSR_IW-1:0] csr_index,
   input  wire logic [CSR_DW-1:0] csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   // sequencer
   rrcp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_mode  (req_if.mode),
      .req_ready (req_if.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // tables and arithmetic
   rrcp_datapath #(
      .MAX_RECORDS (MAX_RECORDS)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_entry_index      (req_if.entry_index),
      .req_entry_first_row  (req_if.entry_first_row),
      .req_entry_first_byte (req_if.entry_first_byte),
      .req_entry_row_count  (req_if.entry_row_count),
      .req_range_start      (req_if.range_start),
      .req_range_stop       (req_if.range_stop),
      .rsp_ready            (rsp_if.ready),
      .rsp_valid            (rsp_if.valid),
      .rsp_source_offset    (rsp_if.source_offset),
      .rsp_dest_offset      (rsp_if.dest_offset),
      .rsp_byte_count       (rsp_if.byte_count),
      .rsp_empty_res        (rsp_if.empty_res),
      .rsp_overflow         (rsp_if.overflow),
      .rsp_last             (rsp_if.last)
   );

endmodule

`default_nettype wire

@@ sv/rrcp_checker.sv @@
// rrcp_checker: port-level checks of the record range copy planner,
// bound to the top level; depends on rrcp_pkg
`default_nettype none

module rrcp_checker import rrcp_pkg::*; (
   input wire logic          clock,
   input wire logic          reset,
   input wire logic          req_valid,
   input wire logic          req_ready,
   input wire logic          req_mode,
   input wire logic          rsp_valid,
   input wire logic          rsp_ready,
   input wire logic [FW-1:0] rsp_source_offset,
   input wire logic [FW-1:0] rsp_dest_offset,
   input wire logic [FW-1:0] rsp_byte_count,
   input wire logic          rsp_empty_res,
   input wire logic          rsp_overflow,
   input wire logic          rsp_last
);

   // a stalled descriptor stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_source_offset)
         && $stable(rsp_dest_offset) && $stable(rsp_byte_count)
         && $stable(rsp_empty_res) && $stable(rsp_overflow) && $stable(rsp_last))
      else $error("descriptor changed while stalled");

   // an empty result is the closing one and carries zeros
   a_empty_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_res |-> rsp_last && !rsp_overflow
         && (rsp_source_offset == '0) && (rsp_dest_offset == '0)
         && (rsp_byte_count == '0))
      else $error("malformed empty result");

   // reset empties the output
   a_reset_out: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid after reset");

   // a range transaction holds off the next one
   a_range_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_mode == MODE_RANGE) |=> !req_ready)
      else $error("request taken while a range is in work");

endmodule

bind record_range_copy_planner rrcp_checker u_rrcp_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_if.valid),
   .req_ready         (req_if.ready),
   .req_mode          (req_if.mode),
   .rsp_valid         (rsp_if.valid),
   .rsp_ready         (rsp_if.ready),
   .rsp_source_offset (rsp_if.source_offset),
   .rsp_dest_offset   (rsp_if.dest_offset),
   .rsp_byte_count    (rsp_if.byte_count),
   .rsp_empty_res     (rsp_if.empty_res),
   .rsp_overflow      (rsp_if.overflow),
   .rsp_last          (rsp_if.last)
);

`default_nettype wire
